// ===== rtl/core/rcp_pkg.sv =====
// Shared widths, constants and types for the ray column projection pipeline.
// Holds the quarter-wave cosine table, built at elaboration.
// No dependencies.
package rcp_pkg;

  localparam int TILE_PIXELS       = 64;
  localparam int SCREEN_ROWS       = 1024;
  localparam int COSINE_INDEX_BITS = 10;

  localparam int DIST_W   = 24;
  localparam int ANGLE_W  = 16;
  localparam int PLANE_W  = 16;
  localparam int HEIGHT_W = 16;
  localparam int ROW_W    = 11;
  localparam int SKIP_W   = 16;

  localparam logic [PLANE_W-1:0] PLANE_DISTANCE_RESET = PLANE_W'(886);

  localparam int COS_ENTRIES = 1 << COSINE_INDEX_BITS;
  localparam int COS_IDX_W   = COSINE_INDEX_BITS + 1;
  localparam int COS_W       = 15;
  localparam int PHASE_W     = ANGLE_W - 2;

  localparam int PERP_W    = DIST_W + COS_W;
  localparam int SCALE_W   = $clog2(TILE_PIXELS * ((1 << PLANE_W) - 1) + 1);
  localparam int NUM_SHIFT = 23;
  localparam int NUM_W     = SCALE_W + NUM_SHIFT;
  localparam int QUO_W     = HEIGHT_W;
  localparam int CMP_W     = PERP_W + QUO_W;
  localparam int DVS_W     = PERP_W + QUO_W - 1;
  localparam int CALC_W    = HEIGHT_W + 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [1:12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef logic [COS_W-1:0] cos_table_t [0:COS_ENTRIES];

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
    logic             sat;
  } div_data_t;

  function automatic logic [COS_W-1:0] cos_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(k)) >> COSINE_INDEX_BITS;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n];
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[COS_W-1:0];
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t tbl;
    for (int k = 0; k <= COS_ENTRIES; k++) begin
      tbl[k] = cos_entry(k);
    end
    return tbl;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

// ===== rtl/core/raycast_column_projection.sv =====
// Top level of the ray column projection pipeline.
// Depends on rcp_pkg, rcp_cos_rom and rcp_div_step.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one ray per transfer: hit
//   distance (Q16.8), ray angle and view angle (16-bit turn fractions).
//   Result channel (out_valid / out_stall) carries the column height, the
//   top and bottom screen rows and the signed texture skip for that ray.
//   cfg_wr_en / cfg_wr_data write the projection-plane distance; write it
//   only while no ray is in flight.
// Stages: after its input transfer, a result passes in order through the
//   angle/index stage, cosine ROM read, multiply, saturation check,
//   16 restoring divider stages (one quotient bit each), row stage.
// Throughput: one ray per cycle unless stalled; divider fully pipelined.
// Reset: synchronous, active low; empties every stage and loads the plane
//   distance with 886.
// Stall: a stalled result holds in the output register; stages behind it
//   keep filling empty slots, and in_stall rises only once the first stage
//   holds an item that cannot move.
module raycast_column_projection (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rcp_pkg::DIST_W-1:0]     in_ray_distance,
  input  logic [rcp_pkg::ANGLE_W-1:0]    in_ray_angle,
  input  logic [rcp_pkg::ANGLE_W-1:0]    in_view_angle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rcp_pkg::HEIGHT_W-1:0]   out_column_height,
  output logic [rcp_pkg::ROW_W-1:0]      out_top_row,
  output logic [rcp_pkg::ROW_W-1:0]      out_bottom_row,
  output logic signed [rcp_pkg::SKIP_W-1:0] out_texture_skip,
  input  logic                           cfg_wr_en,
  input  logic [rcp_pkg::PLANE_W-1:0]    cfg_wr_data
);

  localparam int NDIV = rcp_pkg::QUO_W;

  logic [rcp_pkg::PLANE_W-1:0] plane_distance_r;

  // stage 1: angle difference and table index
  logic                           s1_vld_r;
  logic                           s1_rdy;
  logic [rcp_pkg::DIST_W-1:0]     s1_dist_r;
  logic [rcp_pkg::COS_IDX_W-1:0]  s1_idx_r;
  logic                           s1_neg_r;
  logic [rcp_pkg::ANGLE_W-1:0]    diff_angle;
  logic [1:0]                     quad;
  logic [rcp_pkg::COS_IDX_W-1:0]  phase_idx;
  logic [rcp_pkg::COS_IDX_W-1:0]  s1_idx_nxt;

  // stage 2: cosine magnitude
  logic                           s2_vld_r;
  logic                           s2_rdy;
  logic [rcp_pkg::DIST_W-1:0]     s2_dist_r;
  logic                           s2_neg_r;
  logic [rcp_pkg::COS_W-1:0]      s2_mag;

  // stage 3: products
  logic                           s3_vld_r;
  logic                           s3_rdy;
  logic [rcp_pkg::PERP_W-1:0]     s3_perp_r;
  logic [rcp_pkg::SCALE_W-1:0]    s3_scale_r;
  logic                           s3_nonpos_r;

  // stage 4: saturation check, divider setup
  logic                           s4_vld_r;
  logic                           s4_rdy;
  rcp_pkg::div_data_t             s4_data_r;
  rcp_pkg::div_data_t             s4_data_nxt;
  logic [rcp_pkg::NUM_W-1:0]      num;

  // divider chain
  logic                           div_vld [0:NDIV];
  logic                           div_rdy [0:NDIV];
  rcp_pkg::div_data_t             div_data [0:NDIV];

  // output stage
  logic                           out_vld_r;
  logic                           out_rdy;
  logic [rcp_pkg::HEIGHT_W-1:0]   height_r;
  logic [rcp_pkg::ROW_W-1:0]      top_r;
  logic [rcp_pkg::ROW_W-1:0]      bottom_r;
  logic [rcp_pkg::SKIP_W-1:0]     skip_r;
  logic [rcp_pkg::HEIGHT_W-1:0]   height_nxt;
  logic signed [rcp_pkg::CALC_W-1:0] hs;
  logic signed [rcp_pkg::CALC_W-1:0] rs;
  logic signed [rcp_pkg::CALC_W-1:0] dtop;
  logic signed [rcp_pkg::CALC_W-1:0] top_full;
  logic signed [rcp_pkg::CALC_W-1:0] bsum;
  logic signed [rcp_pkg::CALC_W-1:0] bot_full;
  logic signed [rcp_pkg::CALC_W-1:0] dskip;
  logic signed [rcp_pkg::CALC_W-1:0] skip_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_distance_r <= rcp_pkg::PLANE_DISTANCE_RESET;
    end else if (cfg_wr_en) begin
      plane_distance_r <= cfg_wr_data;
    end
  end

  // ready chain, back to front
  assign out_rdy  = !out_vld_r || !out_stall;
  assign div_rdy[NDIV] = out_rdy;
  assign s4_rdy   = !s4_vld_r || div_rdy[0];
  assign s3_rdy   = !s3_vld_r || s4_rdy;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // stage 1
  always_comb begin
    diff_angle = in_ray_angle - in_view_angle;
    quad       = diff_angle[rcp_pkg::ANGLE_W-1 -: 2];
    phase_idx  = rcp_pkg::COS_IDX_W'(diff_angle[rcp_pkg::PHASE_W-1 -:
                                                 rcp_pkg::COSINE_INDEX_BITS]);
    s1_idx_nxt = quad[0] ? (rcp_pkg::COS_IDX_W'(rcp_pkg::COS_ENTRIES) - phase_idx)
                         : phase_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_dist_r <= in_ray_distance;
      s1_idx_r  <= s1_idx_nxt;
      s1_neg_r  <= quad[1] ^ quad[0];
    end
  end

  // stage 2
  rcp_cos_rom u_cos_rom (
    .clk  (clk),
    .en   (s2_rdy && s1_vld_r),
    .addr (s1_idx_r),
    .data (s2_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_dist_r <= s1_dist_r;
      s2_neg_r  <= s1_neg_r;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      s3_perp_r   <= rcp_pkg::PERP_W'(s2_dist_r) * rcp_pkg::PERP_W'(s2_mag);
      s3_scale_r  <= rcp_pkg::SCALE_W'(rcp_pkg::TILE_PIXELS) *
                     rcp_pkg::SCALE_W'(plane_distance_r);
      s3_nonpos_r <= s2_neg_r || (s2_mag == '0) || (s2_dist_r == '0);
    end
  end

  // stage 4
  always_comb begin
    num             = {s3_scale_r, rcp_pkg::NUM_SHIFT'(0)};
    s4_data_nxt.rem = num;
    s4_data_nxt.dvs = {s3_perp_r, (rcp_pkg::QUO_W - 1)'(0)};
    s4_data_nxt.quo = '0;
    s4_data_nxt.sat = s3_nonpos_r ||
                      (rcp_pkg::CMP_W'(num) >= {s3_perp_r, rcp_pkg::QUO_W'(0)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_vld_r) begin
      s4_data_r <= s4_data_nxt;
    end
  end

  // divider
  assign div_vld[0]  = s4_vld_r;
  assign div_data[0] = s4_data_r;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    rcp_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (div_vld[k]),
      .in_data  (div_data[k]),
      .dn_rdy   (div_rdy[k+1]),
      .up_rdy   (div_rdy[k]),
      .out_vld  (div_vld[k+1]),
      .out_data (div_data[k+1])
    );
  end

  // output stage
  always_comb begin
    height_nxt = div_data[NDIV].sat ? '1 : div_data[NDIV].quo;
    hs         = rcp_pkg::CALC_W'(height_nxt);
    rs         = rcp_pkg::CALC_W'(rcp_pkg::SCREEN_ROWS);
    dtop       = rs - hs;
    top_full   = dtop[rcp_pkg::CALC_W-1] ? '0 : (dtop >>> 1);
    bsum       = (rs + hs) >>> 1;
    bot_full   = (bsum > rs) ? rs : bsum;
    dskip      = hs - rs;
    skip_full  = dskip[rcp_pkg::CALC_W-1] ? -(dtop >>> 1) : (dskip >>> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= div_vld[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && div_vld[NDIV]) begin
      height_r <= height_nxt;
      top_r    <= top_full[rcp_pkg::ROW_W-1:0];
      bottom_r <= bot_full[rcp_pkg::ROW_W-1:0];
      skip_r   <= skip_full[rcp_pkg::SKIP_W-1:0];
    end
  end

  assign out_valid         = out_vld_r;
  assign out_column_height = height_r;
  assign out_top_row       = top_r;
  assign out_bottom_row    = bottom_r;
  assign out_texture_skip  = skip_r;

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_vld_r)
    else $error("input transfer did not land in first stage");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty first stage");

  a_nonpos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && s3_nonpos_r && s4_rdy) |=> (s4_vld_r && s4_data_r.sat))
    else $error("non-positive distance not flagged as saturated");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_vld_r && !s4_vld_r))
    else $error("pipeline not empty after reset");

endmodule

// ===== rtl/core/rcp_cos_rom.sv =====
// Quarter-wave cosine ROM with registered read.
// Depends on rcp_pkg for the table contents and widths.
module rcp_cos_rom (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rcp_pkg::COS_IDX_W-1:0] addr,
  output logic [rcp_pkg::COS_W-1:0]     data
);

  logic [rcp_pkg::COS_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rcp_pkg::COS_TABLE[addr];
    end
  end

  assign data = data_r;

endmodule

// ===== rtl/core/rcp_div_step.sv =====
// One restoring-division stage: resolves one quotient bit per register stage.
// Depends on rcp_pkg for div_data_t.
module rcp_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  rcp_pkg::div_data_t in_data,
  input  logic               dn_rdy,
  output logic               up_rdy,
  output logic               out_vld,
  output rcp_pkg::div_data_t out_data
);

  logic                      vld_r;
  rcp_pkg::div_data_t        data_r;
  rcp_pkg::div_data_t        data_nxt;
  logic [rcp_pkg::DVS_W-1:0] rem_ext;
  logic [rcp_pkg::DVS_W-1:0] diff;
  logic                      ge;

  always_comb begin
    rem_ext       = rcp_pkg::DVS_W'(in_data.rem);
    ge            = rem_ext >= in_data.dvs;
    diff          = rem_ext - in_data.dvs;
    data_nxt.rem  = ge ? diff[rcp_pkg::NUM_W-1:0] : in_data.rem;
    data_nxt.dvs  = in_data.dvs >> 1;
    data_nxt.quo  = {in_data.quo[rcp_pkg::QUO_W-2:0], ge};
    data_nxt.sat  = in_data.sat;
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== sim/raycast_column_projection_test.sv =====
// Self-checking testbench for raycast_column_projection: directed rays, then
// random rays under several plane distances, with random input gaps and output stalls.
// Depends on rcp_pkg and the raycast_column_projection RTL.
module raycast_column_projection_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcp_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [ROW_W-1:0]    top;
    logic [ROW_W-1:0]    bottom;
    logic [SKIP_W-1:0]   skip;
  } column_t;

  typedef struct packed {
    logic [DIST_W-1:0]  hit_dist;
    logic [ANGLE_W-1:0] ray;
    logic [ANGLE_W-1:0] view;
    logic               known;
    column_t            col;
  } ray_row_t;

  localparam int COS_STEPS        = 1 << COSINE_INDEX_BITS;
  localparam int PIPE_LATENCY     = 21;
  localparam int IDLE_PCT         = 27;
  localparam int PHASES           = 6;
  localparam int QUIET_PHASE      = 2;
  localparam int RANDOM_PER_PHASE = 180;
  localparam int LIMIT_CYCLES     = 200000;
  localparam int DIRECTED_COUNT   = 20;

  localparam column_t SATURATED = '{16'hFFFF, 11'd0, 11'd1024, 16'd32255};
  localparam column_t FLAT      = '{16'd0, 11'd512, 11'd512, 16'hFE00};
  localparam column_t NO_COL    = '0;

  localparam ray_row_t DIRECTED_RAYS [0:DIRECTED_COUNT-1] = '{
    '{24'h000000, 16'h0000, 16'h0000, 1'b1, SATURATED},
    '{24'hFFFFFF, 16'h0000, 16'h0000, 1'b1, FLAT},
    '{24'h000001, 16'h0000, 16'h0000, 1'b1, SATURATED},
    '{24'h001000, 16'h8000, 16'h0000, 1'b1, SATURATED},
    '{24'h001000, 16'h4010, 16'h0000, 1'b1, SATURATED},
    '{24'h7FFFFF, 16'hAAAA, 16'h5555, 1'b1, SATURATED},
    '{24'h000100, 16'hBFFF, 16'h0000, 1'b1, SATURATED},
    '{24'h001000, 16'h4000, 16'h0000, 1'b0, NO_COL},
    '{24'h001000, 16'hC000, 16'h0000, 1'b0, NO_COL},
    '{24'h000100, 16'h3FFF, 16'h0000, 1'b0, NO_COL},
    '{24'h000100, 16'h0000, 16'h0001, 1'b0, NO_COL},
    '{24'h000100, 16'hFFFF, 16'hFFFF, 1'b0, NO_COL},
    '{24'h002000, 16'h0000, 16'hFFFF, 1'b0, NO_COL},
    '{24'h800000, 16'hC010, 16'h0000, 1'b0, NO_COL},
    '{24'h800000, 16'h1234, 16'h0100, 1'b0, NO_COL},
    '{24'd14173,  16'h0000, 16'h0000, 1'b0, NO_COL},
    '{24'd14175,  16'h0000, 16'h0000, 1'b0, NO_COL},
    '{24'd14177,  16'h0000, 16'h0000, 1'b0, NO_COL},
    '{24'h010000, 16'h7FFF, 16'h8000, 1'b0, NO_COL},
    '{24'hABCDEF, 16'h2000, 16'hF000, 1'b0, NO_COL}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [DIST_W-1:0]   in_ray_distance;
  logic [ANGLE_W-1:0]  in_ray_angle;
  logic [ANGLE_W-1:0]  in_view_angle;
  logic                out_valid;
  logic                out_stall;
  logic [HEIGHT_W-1:0] out_column_height;
  logic [ROW_W-1:0]    out_top_row;
  logic [ROW_W-1:0]    out_bottom_row;
  logic signed [SKIP_W-1:0] out_texture_skip;
  logic                cfg_wr_en;
  logic [PLANE_W-1:0]  cfg_wr_data;

  logic [15:0]    cos_q15 [0:COS_STEPS];
  logic [PLANE_W-1:0] plane_setting;
  column_t        expected_columns [$];
  bit             quiet;
  int             mismatches;
  int             rays_sent;
  int             results_seen;
  int             saturated_seen;
  int             settings_used;
  int             cycle_count;

  raycast_column_projection dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ray_distance   (in_ray_distance),
    .in_ray_angle      (in_ray_angle),
    .in_view_angle     (in_view_angle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_column_height (out_column_height),
    .out_top_row       (out_top_row),
    .out_bottom_row    (out_bottom_row),
    .out_texture_skip  (out_texture_skip),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] quarter_cos(int unsigned k);
    u64_t   arg;
    u64_t   arg_sq;
    u64_t   term;
    u64_t   rounded;
    longint acc;
    arg    = (64'd1686629713 * u64_t'(k)) >> COSINE_INDEX_BITS;
    arg_sq = (arg * arg) >> 30;
    term   = u64_t'(1) << 30;
    acc    = longint'(1) << 30;
    for (int n = 1; n <= 12; n++) begin
      term = (term * arg_sq) >> 30;
      term = term / u64_t'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (u64_t'(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32767) begin
      rounded = 64'd32767;
    end
    return rounded[15:0];
  endfunction

  function automatic column_t project_column(logic [DIST_W-1:0] hit_dist,
                                             logic [ANGLE_W-1:0] ray,
                                             logic [ANGLE_W-1:0] view);
    logic [ANGLE_W-1:0]           diff;
    logic [COSINE_INDEX_BITS-1:0] idx;
    longint  cosine;
    longint  perp;
    u64_t    num;
    u64_t    quo;
    int      h;
    int      top;
    int      bottom;
    int      skip;
    column_t col;
    diff = ray - view;
    idx  = diff[PHASE_W-1 -: COSINE_INDEX_BITS];
    case (diff[ANGLE_W-1 -: 2])
      2'd0:    cosine = longint'(cos_q15[idx]);
      2'd1:    cosine = -longint'(cos_q15[COS_STEPS - int'(idx)]);
      2'd2:    cosine = -longint'(cos_q15[idx]);
      default: cosine = longint'(cos_q15[COS_STEPS - int'(idx)]);
    endcase
    perp = longint'(hit_dist) * cosine;
    if (perp <= 0) begin
      h = 65535;
    end else begin
      num = (u64_t'(TILE_PIXELS) * u64_t'(plane_setting)) << 23;
      quo = num / u64_t'(perp);
      h   = (quo > 64'd65535) ? 65535 : int'(quo);
    end
    top = (SCREEN_ROWS - h) / 2;
    if (top < 0) begin
      top = 0;
    end
    bottom = (SCREEN_ROWS + h) / 2;
    if (bottom > SCREEN_ROWS) begin
      bottom = SCREEN_ROWS;
    end
    skip       = (h - SCREEN_ROWS) / 2;
    col.height = HEIGHT_W'(h);
    col.top    = ROW_W'(top);
    col.bottom = ROW_W'(bottom);
    col.skip   = SKIP_W'(skip);
    return col;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic send_ray(logic [DIST_W-1:0] hit_dist, logic [ANGLE_W-1:0] ray,
                          logic [ANGLE_W-1:0] view, logic known, column_t col);
    bit taken;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_ray_distance <= hit_dist;
    in_ray_angle    <= ray;
    in_view_angle   <= view;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    expected_columns.push_back(known ? col : project_column(hit_dist, ray, view));
    rays_sent++;
  endtask

  task automatic set_plane(logic [PLANE_W-1:0] value);
    while (expected_columns.size() > 0) begin
      @(posedge clk);
    end
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= value;
    plane_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(negedge clk) begin
    column_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_column_height == 16'hFFFF) begin
        saturated_seen++;
      end
      if (expected_columns.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer: height %0d top %0d bottom %0d skip %0d",
                                out_column_height, out_top_row, out_bottom_row,
                                out_texture_skip));
      end else begin
        want = expected_columns.pop_front();
        if (out_column_height !== want.height || out_top_row !== want.top ||
            out_bottom_row !== want.bottom || out_texture_skip !== want.skip) begin
          note_mismatch($sformatf(
            "result %0d: expected h %0d top %0d bot %0d skip %0d, got %0d %0d %0d %0d",
            results_seen, want.height, want.top, want.bottom, $signed(want.skip),
            out_column_height, out_top_row, out_bottom_row, out_texture_skip));
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) begin
      @(posedge clk);
    end
    $display("raycast_column_projection regression: fail");
    $finish;
  end

  initial begin
    logic [DIST_W-1:0]  hit_dist;
    logic [ANGLE_W-1:0] ray;
    logic [ANGLE_W-1:0] view;
    logic [1:0]         quad;
    int                 pick;
    for (int k = 0; k <= COS_STEPS; k++) begin
      cos_q15[k] = quarter_cos(k);
    end
    plane_setting   = PLANE_DISTANCE_RESET;
    quiet           = 1'b0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_ray_distance <= '0;
    in_ray_angle    <= '0;
    in_view_angle   <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == QUIET_PHASE);
      case (p)
        0:       ;
        1:       set_plane(16'd1);
        2:       set_plane(16'hFFFF);
        3:       set_plane(16'd0);
        default: set_plane(PLANE_W'($urandom_range(2, 16'hFFFE)));
      endcase
      settings_used++;
      if (p == 0) begin
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
          send_ray(DIRECTED_RAYS[i].hit_dist, DIRECTED_RAYS[i].ray, DIRECTED_RAYS[i].view,
                   DIRECTED_RAYS[i].known, DIRECTED_RAYS[i].col);
        end
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick     = $urandom_range(99);
        view     = ANGLE_W'($urandom());
        hit_dist = DIST_W'($urandom());
        if (pick < 55) begin
          hit_dist = hit_dist >> $urandom_range(0, 16);
          ray      = view + ANGLE_W'($urandom_range(0, 16'h3000)) - 16'h1800;
        end else if (pick < 75) begin
          ray = ANGLE_W'($urandom());
        end else if (pick < 85) begin
          quad = 2'($urandom());
          ray  = view + {quad, 14'h0} + ANGLE_W'($urandom_range(0, 64)) - 16'd32;
        end else if (pick < 95) begin
          hit_dist = ($urandom_range(1) == 1) ? DIST_W'($urandom_range(0, 15))
                                              : 24'hFFFFFF - DIST_W'($urandom_range(0, 15));
          ray      = ANGLE_W'($urandom());
        end else begin
          hit_dist = ($urandom_range(1) == 1) ? '0 : 24'hFFFFFF;
          ray      = view;
        end
        send_ray(hit_dist, ray, view, 1'b0, NO_COL);
      end
      in_valid <= 1'b0;
    end

    while (expected_columns.size() > 0) begin
      @(posedge clk);
    end
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("covered %0d rays (%0d directed) under %0d plane distance settings",
             rays_sent, DIRECTED_COUNT, settings_used);
    $display("checked %0d columns, %0d saturated, %0d mismatches",
             results_seen, saturated_seen, mismatches);
    if (mismatches == 0 && expected_columns.size() == 0) begin
      $display("raycast_column_projection regression: pass");
    end else begin
      $display("raycast_column_projection regression: fail");
    end
    $finish;
  end

endmodule
